// ===== rtl/cvp_pkg.sv =====
// shared types, widths and constants of the camera vertex projection block
`timescale 1ns / 1ps

package cvp_pkg;

  // fixed formats
  localparam int COORD_W    = 32;
  localparam int TRIG_W     = 16;
  localparam int FOCAL_W    = 16;
  localparam int TRIG_BITS  = 14;
  localparam int FOCAL_BITS = 12;
  localparam int PROJ_SCALE = 100;
  localparam int SCALE_W    = 7;

  // intermediate widths of the rotation datapath
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = TRIG_W + DIFF_W;
  localparam int ROT_W   = PROD_W + 1 - TRIG_BITS;
  localparam int PROD2_W = TRIG_W + ROT_W;
  localparam int PROJ_W  = PROD2_W + 1 - TRIG_BITS;

  // quotient bits kept by the divider; anything larger saturates
  localparam int QUOT_W = 34;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // parameter defaults
  localparam int DEFAULT_SCREEN_WIDTH  = 1920;
  localparam int DEFAULT_SCREEN_HEIGHT = 1080;
  localparam int DEFAULT_FRACTION_BITS = 16;

  // register reset values
  localparam logic signed [TRIG_W-1:0] TRIG_ONE    = 16'sd16384;
  localparam logic [FOCAL_W-1:0]       FOCAL_RESET = 16'd15287;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CAMERA_X     = 3'd0,
    REG_CAMERA_Y     = 3'd1,
    REG_CAMERA_Z     = 3'd2,
    REG_YAW_COSINE   = 3'd3,
    REG_YAW_SINE     = 3'd4,
    REG_PITCH_COSINE = 3'd5,
    REG_PITCH_SINE   = 3'd6,
    REG_FOCAL_LENGTH = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] camera_x;
    logic signed [COORD_W-1:0] camera_y;
    logic signed [COORD_W-1:0] camera_z;
    logic signed [TRIG_W-1:0]  yaw_cosine;
    logic signed [TRIG_W-1:0]  yaw_sine;
    logic signed [TRIG_W-1:0]  pitch_cosine;
    logic signed [TRIG_W-1:0]  pitch_sine;
    logic [FOCAL_W-1:0]        focal_length;
  } cvp_cfg_t;

  // rotated vertex handed from front to back
  typedef struct packed {
    logic signed [ROT_W-1:0]  rx;
    logic signed [PROJ_W-1:0] ry;
    logic signed [PROJ_W-1:0] pz;
  } cvp_rot_t;

endpackage

// ===== rtl/cvp_front.sv =====
// front part: camera offset and yaw/pitch rotation pipeline
`timescale 1ns / 1ps

module cvp_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cvp_pkg::cvp_cfg_t                    cfg,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [cvp_pkg::COORD_W-1:0]   vertex_x,
  input  logic signed [cvp_pkg::COORD_W-1:0]   vertex_y,
  input  logic signed [cvp_pkg::COORD_W-1:0]   vertex_z,
  output logic                                 push,
  output cvp_pkg::cvp_rot_t                    push_item,
  input  logic                                 queue_full
);

  localparam int DW = cvp_pkg::DIFF_W;
  localparam int PW = cvp_pkg::PROD_W;
  localparam int P2 = cvp_pkg::PROD2_W;
  localparam int TB = cvp_pkg::TRIG_BITS;
  localparam logic signed [PW:0] ROUND1 = (PW + 1)'(1 << (TB - 1));
  localparam logic signed [P2:0] ROUND2 = (P2 + 1)'(1 << (TB - 1));

  logic [4:0] valid;
  logic       en;

  logic signed [DW-1:0] dx, dy, dz, dy2, dy3;
  logic signed [PW-1:0] pa, pb, pc, pd;
  logic signed [cvp_pkg::ROT_W-1:0] rx3, rz3, rx4, rx5;
  logic signed [P2-1:0] qa, qb, qc, qd;
  logic signed [cvp_pkg::PROJ_W-1:0] ry5, pz5;
  logic signed [PW:0] sum_x, sum_z;
  logic signed [P2:0] sum_y, sum_p;

  // the pipeline moves unless its last item cannot enter the queue
  assign en       = !valid[4] || !queue_full;
  assign in_stall = !en;
  assign push     = valid[4] && !queue_full;
  assign push_item = '{rx: rx5, ry: ry5, pz: pz5};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[3:0], in_valid};
    end
  end

  // rounding of the rotation sums, nearest with ties up
  always_comb begin
    sum_x = $signed({pa[PW-1], pa}) - $signed({pb[PW-1], pb}) + ROUND1;
    sum_z = $signed({pc[PW-1], pc}) + $signed({pd[PW-1], pd}) + ROUND1;
    sum_y = $signed({qa[P2-1], qa}) - $signed({qb[P2-1], qb}) + ROUND2;
    sum_p = $signed({qc[P2-1], qc}) + $signed({qd[P2-1], qd}) + ROUND2;
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // offset from camera
      dx <= $signed({vertex_x[31], vertex_x}) - $signed({cfg.camera_x[31], cfg.camera_x});
      dy <= $signed({vertex_y[31], vertex_y}) - $signed({cfg.camera_y[31], cfg.camera_y});
      dz <= $signed({vertex_z[31], vertex_z}) - $signed({cfg.camera_z[31], cfg.camera_z});
      // yaw products
      pa  <= $signed(cfg.yaw_cosine) * dx;
      pb  <= $signed(cfg.yaw_sine) * dz;
      pc  <= $signed(cfg.yaw_sine) * dx;
      pd  <= $signed(cfg.yaw_cosine) * dz;
      dy2 <= dy;
      // yaw result
      rx3 <= sum_x[PW:TB];
      rz3 <= sum_z[PW:TB];
      dy3 <= dy2;
      // pitch products
      qa  <= $signed(cfg.pitch_cosine) * dy3;
      qb  <= $signed(cfg.pitch_sine) * rz3;
      qc  <= $signed(cfg.pitch_sine) * dy3;
      qd  <= $signed(cfg.pitch_cosine) * rz3;
      rx4 <= rx3;
      // pitch result
      ry5 <= sum_y[P2:TB];
      pz5 <= sum_p[P2:TB];
      rx5 <= rx4;
    end
  end

endmodule

// ===== rtl/cvp_queue.sv =====
// short queue that decouples the front and back parts
`timescale 1ns / 1ps

module cvp_queue #(
  parameter int DEPTH = cvp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cvp_pkg::cvp_rot_t push_item,
  output logic              full,
  input  logic              pop,
  output cvp_pkg::cvp_rot_t pop_item,
  output logic              not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cvp_pkg::cvp_rot_t slot [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = slot[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/cvp_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`timescale 1ns / 1ps

module cvp_div #(
  parameter int NW = 76,
  parameter int DW = 40,
  parameter int QB = cvp_pkg::QUOT_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic          tag_in,
  output logic [QB-1:0] quot,
  output logic          ovf,
  output logic          tag_out
);

  logic [DW-1:0] rem  [QB];
  logic [DW-1:0] dd   [QB];
  logic [QB-1:0] low  [QB];
  logic [QB-1:0] quo  [QB+1];
  logic          ov   [QB+1];
  logic          tg   [QB+1];
  logic [NW-1:0] top;
  logic          top_ovf;

  assign top     = num >> QB;
  assign top_ovf = (top >= NW'(den));

  // first stage: overflow check and partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= top_ovf ? '0 : DW'(top);
      dd[0]  <= den;
      low[0] <= num[QB-1:0];
      quo[0] <= '0;
      ov[0]  <= top_ovf;
      tg[0]  <= tag_in;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0] shifted;
    logic        ge;
    assign shifted = {rem[k], low[k][QB-1]};
    assign ge      = (shifted >= {1'b0, dd[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        quo[k+1] <= {quo[k][QB-2:0], ge};
        ov[k+1]  <= ov[k];
        tg[k+1]  <= tg[k];
      end
    end
    if (k + 1 < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? DW'(shifted - {1'b0, dd[k]}) : DW'(shifted);
          dd[k+1]  <= dd[k];
          low[k+1] <= low[k] << 1;
        end
      end
    end
  end

  assign quot    = quo[QB];
  assign ovf     = ov[QB];
  assign tag_out = tg[QB];

endmodule

// ===== rtl/cvp_back.sv =====
// back part: depth clamp, focal scaling, division, screen offset and saturation
`timescale 1ns / 1ps

module cvp_back #(
  parameter int SCREEN_WIDTH  = cvp_pkg::DEFAULT_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = cvp_pkg::DEFAULT_SCREEN_HEIGHT,
  parameter int FRACTION_BITS = cvp_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [cvp_pkg::FOCAL_W-1:0]         focal_length,
  input  logic                                item_valid,
  input  cvp_pkg::cvp_rot_t                   item,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cvp_pkg::COORD_W-1:0]  screen_x,
  output logic signed [cvp_pkg::COORD_W-1:0]  screen_y,
  output logic                                saturated
);

  localparam int FB    = FRACTION_BITS;
  // the quotient must reach well past the largest screen centre, 2^(13+FB)
  localparam int QB_MIN = FB + 14;
  localparam int QB    = (QB_MIN > cvp_pkg::QUOT_W) ? QB_MIN : cvp_pkg::QUOT_W;
  localparam int MAG_W = cvp_pkg::PROJ_W;
  localparam int DEN_W = cvp_pkg::PROJ_W - 1;
  localparam int M1_W  = MAG_W + cvp_pkg::FOCAL_W;
  localparam int M2_W  = M1_W + cvp_pkg::SCALE_W;
  localparam int ASH   = (FB >= cvp_pkg::FOCAL_BITS) ? 0 : cvp_pkg::FOCAL_BITS - FB;
  localparam int NSH   = (FB >= cvp_pkg::FOCAL_BITS) ? FB - cvp_pkg::FOCAL_BITS + 1 : 1;
  localparam int DSH   = ASH + 1;
  localparam int NW    = M2_W + NSH + 1;
  localparam int DW    = DEN_W + DSH;
  localparam int VW    = QB + 6;
  localparam int NV    = QB + 5;
  localparam longint DEPTH_MIN = ((64'sd1 <<< FB) + 50) / 100;
  localparam longint CENTRE_X  = (longint'(SCREEN_WIDTH) <<< FB) >>> 1;
  localparam longint CENTRE_Y  = (longint'(SCREEN_HEIGHT) <<< FB) >>> 1;
  localparam logic signed [VW-1:0] CX = VW'(CENTRE_X);
  localparam logic signed [VW-1:0] CY = VW'(CENTRE_Y);
  localparam logic signed [VW-1:0] VAL_MAX = VW'(64'sh7FFF_FFFF);
  localparam logic signed [VW-1:0] VAL_MIN = -VW'(64'sh8000_0000);
  localparam logic [cvp_pkg::SCALE_W-1:0] SCALE = cvp_pkg::SCALE_W'(cvp_pkg::PROJ_SCALE);

  logic [NV-1:0] valid;
  logic          en;

  logic signed [MAG_W-1:0] coord [2];
  logic [MAG_W-1:0]        mag   [2];
  logic [M1_W-1:0]         m1    [2];
  logic [NW-1:0]           num   [2];
  logic                    sgn1  [2];
  logic                    sgn2  [2];
  logic                    sgn3  [2];
  logic [DEN_W-1:0]        den1, den2;
  logic [DW-1:0]           dvs;
  logic [QB-1:0]           quot  [2];
  logic                    ovf   [2];
  logic                    neg   [2];
  logic signed [VW-1:0]    val   [2];
  logic signed [VW-1:0]    centre [2];
  logic [cvp_pkg::COORD_W-1:0] res [2];
  logic                    clip  [2];

  // stages move together unless the finished item is held
  assign en        = !(valid[NV-1] && out_stall);
  assign pop       = item_valid && en;
  assign out_valid = valid[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[NV-2:0], item_valid};
    end
  end

  assign coord[0] = {{(MAG_W - cvp_pkg::ROT_W){item.rx[cvp_pkg::ROT_W-1]}}, item.rx};
  assign coord[1] = item.ry;
  assign centre[0] = CX;
  assign centre[1] = CY;

  // magnitude, clamped depth, focal and scale products, dividend
  always_ff @(posedge clk) begin
    if (en) begin
      den1 <= (item.pz <= 0) ? DEN_W'(DEPTH_MIN) : DEN_W'(item.pz);
      den2 <= den1;
      dvs  <= DW'(den2) << DSH;
      for (int i = 0; i < 2; i++) begin
        mag[i]  <= coord[i][MAG_W-1] ? MAG_W'(-coord[i]) : MAG_W'(coord[i]);
        sgn1[i] <= coord[i][MAG_W-1];
        m1[i]   <= mag[i] * focal_length;
        sgn2[i] <= sgn1[i];
        num[i]  <= ((NW'(m1[i]) * NW'(SCALE)) << NSH) + (NW'(den2) << ASH);
        sgn3[i] <= sgn2[i];
      end
    end
  end

  // one divider per coordinate
  for (genvar i = 0; i < 2; i++) begin : g_lane
    cvp_div #(
      .NW (NW),
      .DW (DW),
      .QB (QB)
    ) u_div (
      .clk     (clk),
      .en      (en),
      .num     (num[i]),
      .den     (dvs),
      .tag_in  (sgn3[i]),
      .quot    (quot[i]),
      .ovf     (ovf[i]),
      .tag_out (neg[i])
    );
  end

  // sign, centre offset and saturation
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      val[i] = (neg[i] ? -VW'(quot[i]) : VW'(quot[i])) + centre[i];
      if ((ovf[i] && !neg[i]) || (!ovf[i] && val[i] > VAL_MAX)) begin
        res[i]  = 32'h7FFF_FFFF;
        clip[i] = 1'b1;
      end else if ((ovf[i] && neg[i]) || val[i] < VAL_MIN) begin
        res[i]  = 32'h8000_0000;
        clip[i] = 1'b1;
      end else begin
        res[i]  = val[i][cvp_pkg::COORD_W-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      screen_x  <= res[0];
      screen_y  <= res[1];
      saturated <= clip[0] || clip[1];
    end
  end

endmodule

// ===== rtl/camera_vertex_projection.sv =====
// top level of the camera vertex projection block
`timescale 1ns / 1ps

// Projects one world-space vertex (signed Q16.16 by default) through a yaw/pitch
// camera to one screen point per item. Throughput is one item per cycle while no stall
// holds the flow. The path runs through five rotation stages, the four-entry queue, three
// scaling stages, a 35-stage restoring divider (an overflow check, then one quotient bit
// per stage; the longest part) and an output register. Results that do not fit 32 bits
// saturate and raise saturated. Configuration writes take effect at once and must be made
// while no item is in flight.
module camera_vertex_projection #(
  parameter int SCREEN_WIDTH  = cvp_pkg::DEFAULT_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = cvp_pkg::DEFAULT_SCREEN_HEIGHT,
  parameter int FRACTION_BITS = cvp_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [cvp_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [cvp_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [cvp_pkg::COORD_W-1:0]     vertex_x,
  input  logic signed [cvp_pkg::COORD_W-1:0]     vertex_y,
  input  logic signed [cvp_pkg::COORD_W-1:0]     vertex_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [cvp_pkg::COORD_W-1:0]     screen_x,
  output logic signed [cvp_pkg::COORD_W-1:0]     screen_y,
  output logic                                   saturated
);

  cvp_pkg::cvp_cfg_t cfg;
  cvp_pkg::cvp_rot_t push_item, pop_item;
  logic              push, pop, queue_full, queue_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.camera_x     <= '0;
      cfg.camera_y     <= '0;
      cfg.camera_z     <= '0;
      cfg.yaw_cosine   <= cvp_pkg::TRIG_ONE;
      cfg.yaw_sine     <= '0;
      cfg.pitch_cosine <= cvp_pkg::TRIG_ONE;
      cfg.pitch_sine   <= '0;
      cfg.focal_length <= cvp_pkg::FOCAL_RESET;
    end else if (cfg_write) begin
      unique case (cvp_pkg::cfg_reg_t'(cfg_index))
        cvp_pkg::REG_CAMERA_X:     cfg.camera_x     <= cfg_data;
        cvp_pkg::REG_CAMERA_Y:     cfg.camera_y     <= cfg_data;
        cvp_pkg::REG_CAMERA_Z:     cfg.camera_z     <= cfg_data;
        cvp_pkg::REG_YAW_COSINE:   cfg.yaw_cosine   <= cfg_data[cvp_pkg::TRIG_W-1:0];
        cvp_pkg::REG_YAW_SINE:     cfg.yaw_sine     <= cfg_data[cvp_pkg::TRIG_W-1:0];
        cvp_pkg::REG_PITCH_COSINE: cfg.pitch_cosine <= cfg_data[cvp_pkg::TRIG_W-1:0];
        cvp_pkg::REG_PITCH_SINE:   cfg.pitch_sine   <= cfg_data[cvp_pkg::TRIG_W-1:0];
        cvp_pkg::REG_FOCAL_LENGTH: cfg.focal_length <= cfg_data[cvp_pkg::FOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  // rotation front
  cvp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .vertex_x   (vertex_x),
    .vertex_y   (vertex_y),
    .vertex_z   (vertex_z),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  // decoupling queue
  cvp_queue #(
    .DEPTH (cvp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (queue_valid)
  );

  // projection back
  cvp_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .focal_length (cfg.focal_length),
    .item_valid   (queue_valid),
    .item         (pop_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .saturated    (saturated)
  );

endmodule

// ===== rtl/cvp_checker.sv =====
// port-level assertions for the camera vertex projection block, with its bind
`timescale 1ns / 1ps

module cvp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [cvp_pkg::COORD_W-1:0]  screen_x,
  input logic signed [cvp_pkg::COORD_W-1:0]  screen_y,
  input logic                                saturated
);

  // a held item stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output item dropped while stalled");

  // a held item keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(screen_x) && $stable(screen_y) && $stable(saturated))
    else $error("output item changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output item present after reset");

  // a saturated item carries a clipped coordinate
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (screen_x == 32'sh7FFF_FFFF) || (screen_x == -32'sh8000_0000) ||
      (screen_y == 32'sh7FFF_FFFF) || (screen_y == -32'sh8000_0000))
    else $error("saturated set without a clipped coordinate");

endmodule

bind camera_vertex_projection cvp_checker u_cvp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .screen_x  (screen_x),
  .screen_y  (screen_y),
  .saturated (saturated)
);

// ===== dv/camera_vertex_projection_test.sv =====
// self-checking testbench of the camera vertex projection block
`timescale 1ns / 1ps

module camera_vertex_projection_test;

  localparam longint CENTRE_X   = (longint'(1920) << 16) >>> 1;
  localparam longint CENTRE_Y   = (longint'(1080) << 16) >>> 1;
  localparam longint DEPTH_MIN  = ((longint'(1) << 16) + 50) / 100;
  localparam longint INT32_HI   = 64'sd2147483647;
  localparam longint INT32_LO   = -64'sd2147483648;
  localparam int     DRAIN_WAIT = 60;
  localparam int     IDLE_LIMIT = 3000;
  localparam int     HOLD_OFF   = 300;
  localparam int     PHASES     = 6;
  localparam int     PHASE_ITEMS = 100;

  typedef struct {
    logic signed [cvp_pkg::COORD_W-1:0] sx;
    logic signed [cvp_pkg::COORD_W-1:0] sy;
    logic                               sat;
  } screen_pt_t;

  typedef struct {
    logic signed [cvp_pkg::COORD_W-1:0] vx;
    logic signed [cvp_pkg::COORD_W-1:0] vy;
    logic signed [cvp_pkg::COORD_W-1:0] vz;
    bit                                 known;
    screen_pt_t                         pt;
  } vertex_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [cvp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [cvp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [cvp_pkg::COORD_W-1:0] vertex_x = '0;
  logic signed [cvp_pkg::COORD_W-1:0] vertex_y = '0;
  logic signed [cvp_pkg::COORD_W-1:0] vertex_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [cvp_pkg::COORD_W-1:0] screen_x;
  logic signed [cvp_pkg::COORD_W-1:0] screen_y;
  logic saturated;

  // predictor copy of the registers
  longint cam_x, cam_y, cam_z, yaw_c, yaw_s, pitch_c, pitch_s;
  logic [cvp_pkg::FOCAL_W-1:0] focal;

  screen_pt_t pending_points[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 0;
  int mismatches = 0;
  int points_checked = 0;
  int points_saturated = 0;
  int idle_cycles = 0;

  camera_vertex_projection u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .screen_x(screen_x), .screen_y(screen_y), .saturated(saturated)
  );

  always #5 clk = ~clk;

  // back to F fraction bits, nearest with ties toward +infinity
  function automatic longint round_trig(longint v);
    return (v + 64'sd8192) >>> cvp_pkg::TRIG_BITS;
  endfunction

  // 100 * coord * focal / depth rounded, plus centre, saturated
  function automatic longint scale_coord(longint c, longint depth, longint centre,
                                         inout bit sat);
    logic [127:0] mag, den, whole, rem, q;
    longint val;
    mag = 128'((c < 0) ? -c : c);
    mag = mag * focal * 128'd100;
    den = 128'(depth);
    whole = mag / den;
    rem = mag % den;
    if (whole >= (128'd1 << 34)) q = 128'd1 << 40;
    else q = (whole << 4) + ((rem << 5) + den) / (den << 1);
    val = (c < 0) ? -longint'(q) : longint'(q);
    val += centre;
    if (val > INT32_HI) begin
      sat = 1;
      return INT32_HI;
    end
    if (val < INT32_LO) begin
      sat = 1;
      return INT32_LO;
    end
    return val;
  endfunction

  function automatic screen_pt_t project_vertex(logic signed [cvp_pkg::COORD_W-1:0] vx,
                                                logic signed [cvp_pkg::COORD_W-1:0] vy,
                                                logic signed [cvp_pkg::COORD_W-1:0] vz);
    longint dx, dy, dz, rx, rz, ry, pz;
    bit sat;
    screen_pt_t pt;
    sat = 0;
    dx = longint'(vx) - cam_x;
    dy = longint'(vy) - cam_y;
    dz = longint'(vz) - cam_z;
    rx = round_trig(yaw_c * dx - yaw_s * dz);
    rz = round_trig(yaw_s * dx + yaw_c * dz);
    ry = round_trig(pitch_c * dy - pitch_s * rz);
    pz = round_trig(pitch_s * dy + pitch_c * rz);
    if (pz <= 0) pz = DEPTH_MIN;
    pt.sx = 32'(scale_coord(rx, pz, CENTRE_X, sat));
    pt.sy = 32'(scale_coord(ry, pz, CENTRE_Y, sat));
    pt.sat = sat;
    return pt;
  endfunction

  // register write, mirrored into the predictor
  task automatic write_reg(cvp_pkg::cfg_reg_t idx, logic [cvp_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      cvp_pkg::REG_CAMERA_X:     cam_x = longint'($signed(value));
      cvp_pkg::REG_CAMERA_Y:     cam_y = longint'($signed(value));
      cvp_pkg::REG_CAMERA_Z:     cam_z = longint'($signed(value));
      cvp_pkg::REG_YAW_COSINE:   yaw_c = longint'($signed(value[15:0]));
      cvp_pkg::REG_YAW_SINE:     yaw_s = longint'($signed(value[15:0]));
      cvp_pkg::REG_PITCH_COSINE: pitch_c = longint'($signed(value[15:0]));
      cvp_pkg::REG_PITCH_SINE:   pitch_s = longint'($signed(value[15:0]));
      cvp_pkg::REG_FOCAL_LENGTH: focal = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [15:0] yc, logic [15:0] ys, logic [15:0] pc,
                           logic [15:0] ps, logic [15:0] fl);
    // stop offering the last vertex before the pipeline drains
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    write_reg(cvp_pkg::REG_CAMERA_X, cx);
    write_reg(cvp_pkg::REG_CAMERA_Y, cy);
    write_reg(cvp_pkg::REG_CAMERA_Z, cz);
    write_reg(cvp_pkg::REG_YAW_COSINE, {16'd0, yc});
    write_reg(cvp_pkg::REG_YAW_SINE, {16'd0, ys});
    write_reg(cvp_pkg::REG_PITCH_COSINE, {16'd0, pc});
    write_reg(cvp_pkg::REG_PITCH_SINE, {16'd0, ps});
    write_reg(cvp_pkg::REG_FOCAL_LENGTH, {16'd0, fl});
  endtask

  // offer one vertex and wait for it to be taken
  task automatic send_vertex(logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] vz, bit known, screen_pt_t pt);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    vertex_x <= vx;
    vertex_y <= vy;
    vertex_z <= vz;
    do @(posedge clk); while (in_stall);
    pending_points.push_back(known ? pt : project_vertex(vx, vy, vz));
  endtask

  function automatic logic [15:0] rand_trig();
    return 16'($signed($urandom_range(32768)) - 32'sd16384);
  endfunction

  function automatic logic signed [31:0] rand_offset(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  // receiver stall, with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        repeat (HOLD_OFF) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    screen_pt_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point %h %h %b", screen_x, screen_y, saturated);
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (want.sat) points_saturated++;
        if (screen_x !== want.sx || screen_y !== want.sy || saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want x=%h y=%h sat=%b, got x=%h y=%h sat=%b",
                     want.sx, want.sy, want.sat, screen_x, screen_y, saturated);
        end
      end
    end
  end

  vertex_row_t directed_rows[$];
  screen_pt_t no_pt;

  initial begin
    logic signed [31:0] vx, vy, vz;
    cam_x = 0; cam_y = 0; cam_z = 0;
    yaw_c = 16384; yaw_s = 0; pitch_c = 16384; pitch_s = 0;
    focal = 16'd15287;
    no_pt = '{sx: '0, sy: '0, sat: 1'b0};

    // directed vertices at reset settings
    directed_rows = '{
      '{32'sd0, 32'sd0, 32'sd0, 1, '{32'(CENTRE_X), 32'(CENTRE_Y), 1'b0}},
      '{32'sd0, 32'sd0, -32'sd327680, 1, '{32'(CENTRE_X), 32'(CENTRE_Y), 1'b0}},
      '{32'h7fffffff, 32'sd0, 32'sd0, 1, '{32'h7fffffff, 32'(CENTRE_Y), 1'b1}},
      '{32'h80000000, 32'sd0, 32'sd0, 1, '{32'h80000000, 32'(CENTRE_Y), 1'b1}},
      '{32'sd0, 32'h80000000, 32'sd0, 1, '{32'(CENTRE_X), 32'h80000000, 1'b1}},
      '{32'sd0, 32'h7fffffff, 32'sd0, 1, '{32'(CENTRE_X), 32'h7fffffff, 1'b1}},
      '{32'sd0, 32'sd0, 32'sd655360, 0, no_pt},
      '{32'sd65536, -32'sd65536, 32'sd327680, 0, no_pt},
      '{-32'sd1, -32'sd1, 32'sd1, 0, no_pt},
      '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, no_pt},
      '{32'h80000000, 32'h7fffffff, 32'h80000000, 0, no_pt},
      '{32'sd123456, 32'sd98765, 32'h7fffffff, 0, no_pt}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 9;
    recv_idle_pct = 67;
    foreach (directed_rows[i])
      send_vertex(directed_rows[i].vx, directed_rows[i].vy, directed_rows[i].vz,
                  directed_rows[i].known, directed_rows[i].pt);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_all(0, 0, 0, 16'd16384, 16'd0, 16'd16384, 16'd0, 16'd15287);
        1: write_all(rand_offset(50 << 16), rand_offset(50 << 16), rand_offset(50 << 16),
                     rand_trig(), rand_trig(), rand_trig(), rand_trig(), 16'($urandom));
        2: write_all(32'h80000000, 32'h7fffffff, 32'h80000000, -16'sd16384, 16'sd16384,
                     16'sd16384, -16'sd16384, 16'hffff);
        3: write_all(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'sd16384, -16'sd16384,
                     -16'sd16384, 16'sd16384, 16'd0);
        default: write_all($urandom, $urandom, $urandom, rand_trig(), rand_trig(),
                           rand_trig(), rand_trig(), 16'($urandom));
      endcase
      case (p / 2)
        0: begin send_idle_pct = 9; recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 9; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 20) hold_req = 1;
        case ($urandom_range(3))
          0: begin vx = $urandom; vy = $urandom; vz = $urandom; end
          1: begin
            vx = 32'(cam_x) + rand_offset(200 << 16);
            vy = 32'(cam_y) + rand_offset(200 << 16);
            vz = 32'(cam_z) + rand_offset(400 << 16);
          end
          default: begin
            vx = 32'(cam_x) + rand_offset(20 << 16);
            vy = 32'(cam_y) + rand_offset(20 << 16);
            vz = 32'(cam_z) + $signed($urandom_range(1000 << 16));
          end
        endcase
        send_vertex(vx, vy, vz, 0, no_pt);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("checked %0d points (%0d saturated) over %0d register settings,",
             points_checked, points_saturated, PHASES + 1);
    $display("with sender and receiver stalls and one long output hold-off");
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
